// ===== hdl/tno_pkg.sv =====
`default_nettype none
package tno_pkg;

  localparam logic [7:0] TN_IAC        = 8'd255;
  localparam logic [7:0] TN_DONT       = 8'd254;
  localparam logic [7:0] TN_DO         = 8'd253;
  localparam logic [7:0] TN_WONT       = 8'd252;
  localparam logic [7:0] TN_WILL       = 8'd251;
  localparam logic [7:0] TN_SB         = 8'd250;
  localparam logic [7:0] TN_SE         = 8'd240;
  localparam logic [7:0] TN_FIRST_CMD  = 8'd236;
  localparam logic [7:0] TN_LAST_PLAIN = 8'd249;
  localparam logic [7:0] TN_NUL        = 8'd0;

  localparam logic [7:0] OPT_BINARY = 8'd0;
  localparam logic [7:0] OPT_ECHO   = 8'd1;
  localparam logic [7:0] OPT_SGA    = 8'd3;
  localparam logic [7:0] OPT_TTYPE  = 8'd24;
  localparam logic [7:0] OPT_NAWS   = 8'd31;
  localparam logic [7:0] QUAL_SEND  = 8'd1;

  localparam int unsigned CFG_INDEX_W = 8;
  localparam logic [CFG_INDEX_W-1:0] CFG_WINDOW_COLUMNS = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_WINDOW_ROWS    = 8'd1;

  localparam logic [15:0] WINDOW_COLUMNS_RESET = 16'd80;
  localparam logic [15:0] WINDOW_ROWS_RESET    = 16'd50;

  typedef enum logic [2:0] {
    ST_IDLE      = 3'd0,
    ST_AFTER_IAC = 3'd1,
    ST_AFTER_CMD = 3'd2,
    ST_SB_TTYPE  = 3'd3,
    ST_SEND      = 3'd4
  } parse_stage_t;

  typedef enum logic [1:0] {
    KIND_DATA    = 2'd0,
    KIND_SEND    = 2'd1,
    KIND_REQUEST = 2'd2
  } out_kind_t;

  typedef logic [3:0] burst_idx_t;
  localparam burst_idx_t IDX_TRIPLE_LAST = 4'd2;
  localparam burst_idx_t IDX_NAWS_LAST   = 4'd11;

endpackage
`default_nettype wire

// ===== hdl/telnet_option_negotiator.sv =====
// Client-side telnet receive filter with option negotiation.
// The input channel (in_valid, in_ready, in_rx_byte) takes one byte received
// from the server per transaction. The result channel (out_valid, out_ready,
// out_kind, out_value, out_last) delivers zero or more results per input byte:
// data bytes for the host, reply bytes for the server, or a terminal-type
// request event. out_last marks the final result caused by one input byte.
// The configuration channel (cfg_valid, cfg_ready, cfg_index, cfg_data) sets
// the window columns (index 0) and rows (index 1) used in the window-size
// reply; it is always ready and must only be written while the block is idle.
// Each input byte is parsed in the cycle it is accepted and its first result
// is presented on the next cycle. Results leave one per cycle from an output
// sequencer while out_ready is high, so a byte yields 1, 3 or 12 results. A
// new byte is accepted in the same cycle that the final result of the previous
// one is taken, so pass-through data sustains one byte per cycle while the
// receiver is ready. A reply triple holds 3 results and the NAWS answer 12.
// When the receiver stalls, the current result holds and in_ready falls once
// a result is waiting. Reset clears the parser, the option flags and the
// sequencer, and restores the window size to 80 columns by 50 rows.
`default_nettype none
module telnet_option_negotiator (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              in_valid,
  output logic                             in_ready,
  input  wire  [7:0]                       in_rx_byte,
  output logic                             out_valid,
  input  wire                              out_ready,
  output logic [1:0]                       out_kind,
  output logic [7:0]                       out_value,
  output logic                             out_last,
  input  wire                              cfg_valid,
  output logic                             cfg_ready,
  input  wire  [tno_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  wire  [15:0]                      cfg_data
);
  import tno_pkg::*;

  logic [15:0]  window_columns_r;
  logic [15:0]  window_rows_r;
  parse_stage_t stage_r, stage_nxt;
  logic [7:0]   pend_r, pend_nxt;
  logic         binary_r, binary_nxt;
  logic         echo_r, echo_nxt;
  logic         sga_r, sga_nxt;

  logic         burst_valid_r;
  out_kind_t    burst_kind_r;
  logic [7:0]   burst_cmd_r;
  logic [7:0]   burst_byte_r;
  logic         burst_naws_r;
  burst_idx_t   idx_r;

  logic         emit_valid;
  out_kind_t    emit_kind;
  logic [7:0]   emit_cmd;
  logic [7:0]   emit_byte;
  logic         emit_naws;

  logic         in_fire;
  logic         out_fire;
  logic [7:0]   c;

  assign c         = in_rx_byte;
  assign cfg_ready = 1'b1;
  assign in_fire   = in_valid && in_ready;
  assign out_fire  = out_valid && out_ready;
  assign in_ready  = !burst_valid_r || (out_ready && out_last);

  always_comb begin
    stage_nxt  = stage_r;
    pend_nxt   = pend_r;
    binary_nxt = binary_r;
    echo_nxt   = echo_r;
    sga_nxt    = sga_r;
    emit_valid = 1'b0;
    emit_kind  = KIND_DATA;
    emit_cmd   = TN_NUL;
    emit_byte  = c;
    emit_naws  = 1'b0;
    case (stage_r)
      ST_IDLE: begin
        if (c == TN_IAC) begin
          stage_nxt = ST_AFTER_IAC;
        end else if (c != TN_NUL) begin
          emit_valid = 1'b1;
        end
      end
      ST_AFTER_IAC: begin
        if (c == TN_IAC) begin
          if (binary_r) begin
            stage_nxt  = ST_IDLE;
            emit_valid = 1'b1;
          end
        end else if (c inside {[TN_FIRST_CMD:TN_LAST_PLAIN]}) begin
          stage_nxt = ST_IDLE;
        end else begin
          pend_nxt  = c;
          stage_nxt = ST_AFTER_CMD;
        end
      end
      ST_AFTER_CMD: begin
        stage_nxt = ST_IDLE;
        if (pend_r >= TN_FIRST_CMD) begin
          emit_kind = KIND_SEND;
          case (pend_r)
            TN_DONT: begin
              if (c == TN_IAC) begin
                stage_nxt = ST_AFTER_IAC;
              end else begin
                emit_valid = 1'b1;
                emit_cmd   = TN_WONT;
              end
            end
            TN_DO: begin
              emit_valid = 1'b1;
              emit_cmd   = TN_WILL;
              case (c)
                OPT_ECHO: begin
                  emit_cmd = TN_WONT;
                  echo_nxt = 1'b1;
                end
                OPT_BINARY: binary_nxt = 1'b1;
                OPT_SGA:    sga_nxt    = 1'b1;
                OPT_TTYPE:  emit_cmd   = TN_WILL;
                OPT_NAWS:   emit_naws  = 1'b1;
                default:    emit_cmd   = TN_WONT;
              endcase
            end
            TN_WILL: begin
              emit_cmd = TN_DO;
              case (c)
                OPT_ECHO: begin
                  emit_valid = !echo_r;
                  echo_nxt   = 1'b1;
                end
                OPT_BINARY: begin
                  emit_valid = !binary_r;
                  binary_nxt = 1'b1;
                end
                OPT_SGA: begin
                  emit_valid = !sga_r;
                  sga_nxt    = 1'b1;
                end
                default: begin
                  emit_valid = 1'b1;
                  emit_cmd   = TN_DONT;
                end
              endcase
            end
            TN_WONT: begin
              emit_valid = 1'b1;
              emit_cmd   = TN_DONT;
            end
            TN_SB: begin
              if (c == OPT_TTYPE) begin
                stage_nxt = ST_SB_TTYPE;
              end
            end
            default: ;
          endcase
        end
      end
      ST_SB_TTYPE: begin
        stage_nxt = (c == QUAL_SEND) ? ST_SEND : ST_IDLE;
      end
      ST_SEND: begin
        if (c == TN_SE) begin
          emit_valid = 1'b1;
          emit_kind  = KIND_REQUEST;
          stage_nxt  = ST_IDLE;
        end
      end
      default: begin
        stage_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_columns_r <= WINDOW_COLUMNS_RESET;
      window_rows_r    <= WINDOW_ROWS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_WINDOW_COLUMNS: window_columns_r <= cfg_data;
        CFG_WINDOW_ROWS:    window_rows_r    <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_r  <= ST_IDLE;
      pend_r   <= TN_NUL;
      binary_r <= 1'b0;
      echo_r   <= 1'b0;
      sga_r    <= 1'b0;
    end else if (in_fire) begin
      stage_r  <= stage_nxt;
      pend_r   <= pend_nxt;
      binary_r <= binary_nxt;
      echo_r   <= echo_nxt;
      sga_r    <= sga_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      burst_valid_r <= 1'b0;
      idx_r         <= '0;
    end else if (in_fire && emit_valid) begin
      burst_valid_r <= 1'b1;
      idx_r         <= '0;
    end else if (out_fire && out_last) begin
      burst_valid_r <= 1'b0;
    end else if (out_fire) begin
      idx_r <= idx_r + burst_idx_t'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && emit_valid) begin
      burst_kind_r <= emit_kind;
      burst_cmd_r  <= emit_cmd;
      burst_byte_r <= emit_byte;
      burst_naws_r <= emit_naws;
    end
  end

  always_comb begin
    out_valid = burst_valid_r;
    out_kind  = burst_kind_r;
    out_last  = 1'b1;
    out_value = TN_NUL;
    case (burst_kind_r)
      KIND_DATA: out_value = burst_byte_r;
      KIND_SEND: begin
        out_last = burst_naws_r ? (idx_r == IDX_NAWS_LAST) : (idx_r == IDX_TRIPLE_LAST);
        case (idx_r)
          4'd0:    out_value = TN_IAC;
          4'd1:    out_value = burst_cmd_r;
          4'd2:    out_value = burst_byte_r;
          4'd3:    out_value = TN_IAC;
          4'd4:    out_value = TN_SB;
          4'd5:    out_value = OPT_NAWS;
          4'd6:    out_value = window_columns_r[15:8];
          4'd7:    out_value = window_columns_r[7:0];
          4'd8:    out_value = window_rows_r[15:8];
          4'd9:    out_value = window_rows_r[7:0];
          4'd10:   out_value = TN_IAC;
          4'd11:   out_value = TN_SE;
          default: out_value = TN_NUL;
        endcase
      end
      KIND_REQUEST: out_value = TN_NUL;
      default:      out_value = TN_NUL;
    endcase
  end

endmodule
`default_nettype wire
